>>> src/rlw_pkg.sv
// Package for the RGB LED register writer: constants, register codes and
// the word passed from the input stage to the output buffer.
// No dependencies.
`timescale 1ns / 1ps

package rlw_pkg;

  // Channel levels (percent), with an out-of-range marker for "never set"
  localparam logic [6:0] LEVEL_MAX  = 7'd100;
  localparam logic [6:0] LEVEL_NONE = 7'd101;

  // Enable word: all channels on, and the "never written" marker
  localparam logic [7:0] ENABLE_ALL  = 8'h3F;
  localparam logic [7:0] ENABLE_NONE = 8'hFF;
  localparam logic [7:0] RED_BITS    = 8'h0C;
  localparam logic [7:0] GREEN_BITS  = 8'h30;
  localparam logic [7:0] BLUE_BITS   = 8'h03;

  // Per-channel enable bits, processing order red, green, blue
  localparam int unsigned NUM_CHAN = 3;
  localparam logic [NUM_CHAN-1:0][7:0] CHAN_BITS = {BLUE_BITS, GREEN_BITS, RED_BITS};

  // Reset value of the full scale current code
  localparam logic [7:0] FULL_SCALE_RESET = 8'd39;

  // x / 99 as (x * RECIP_99) >> RECIP_SHIFT, exact for x below 2^15
  localparam logic [15:0] RECIP_99    = 16'd42367;
  localparam int unsigned RECIP_SHIFT = 22;

  // Product width: (level - 1) * full scale, at most 99 * 255
  localparam int unsigned PROD_W = 15;

  // Configuration register index (paddr[2])
  localparam logic CFG_FULL_SCALE = 1'b0;

  // Target register of an output word
  typedef enum logic [1:0] {
    REG_BLUE   = 2'd0,
    REG_RED    = 2'd1,
    REG_GREEN  = 2'd2,
    REG_ENABLE = 2'd3
  } reg_idx_e;

  // Work for one request, handed from the input stage to the output buffer
  typedef struct packed {
    logic [NUM_CHAN-1:0]             emit;      // current write per channel
    logic                            en_write;  // enable word changed
    logic [7:0]                      en_value;
    logic [NUM_CHAN-1:0][PROD_W-1:0] prod;      // (level - 1) * full scale
  } job_t;

endpackage

>>> src/rlw_cfg_regs.sv
// APB configuration register for the RGB LED register writer: full scale
// current code. Depends on rlw_pkg.
`timescale 1ns / 1ps

module rlw_cfg_regs
  import rlw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  full_scale_o
);

  logic [7:0] full_scale_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register write in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FULL_SCALE_RESET;
    end else if (wr_en && (paddr[2] == CFG_FULL_SCALE)) begin
      full_scale_q <= pwdata[7:0];
    end
  end

  // Read-back; unused addresses read zero
  assign prdata = (paddr[2] == CFG_FULL_SCALE) ? {24'd0, full_scale_q} : 32'd0;

  assign full_scale_o = full_scale_q;

endmodule

>>> src/rlw_front.sv
// Input stage: clamps the three power requests, tracks channel levels and
// the enable word, and registers the products for the current codes.
// Depends on rlw_pkg.
`timescale 1ns / 1ps

module rlw_front
  import rlw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_power, green_power, blue_power
  input  logic [7:0]  full_scale_i,
  output logic        job_valid_o,
  output job_t        job_o,
  input  logic        job_take_i
);

  logic [NUM_CHAN-1:0][6:0] lvl_q;
  logic [7:0]               en_q;
  logic                     job_valid_q;
  job_t                     job_q;

  logic [NUM_CHAN-1:0][6:0] lvl;
  logic [NUM_CHAN-1:0]      chg;
  logic [7:0]               en_d;
  logic                     accept;
  job_t                     job_d;

  function automatic logic [6:0] clamp_level(input logic [7:0] b);
    clamp_level = (b > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : b[6:0];
  endfunction

  assign s_axis_tready = !job_valid_q || job_take_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Channel updates in red, green, blue order on the working enable word
  always_comb begin
    en_d = (en_q == ENABLE_NONE) ? ENABLE_ALL : en_q;
    for (int c = 0; c < NUM_CHAN; c++) begin
      lvl[c] = clamp_level(s_axis_tdata[8*c +: 8]);
      chg[c] = (lvl[c] != lvl_q[c]);
      if (chg[c]) begin
        if (lvl[c] == 7'd0) begin
          en_d = en_d & (ENABLE_ALL & ~CHAN_BITS[c]);
        end else begin
          en_d = en_d | CHAN_BITS[c];
        end
      end
    end
  end

  // Work word: which writes to make and the products to scale
  always_comb begin
    job_d.en_write = (en_d != en_q);
    job_d.en_value = en_d;
    for (int c = 0; c < NUM_CHAN; c++) begin
      job_d.emit[c] = chg[c] && (lvl[c] != 7'd0);
      job_d.prod[c] = {8'd0, lvl[c] - 7'd1} * {7'd0, full_scale_i};
    end
  end

  // Remembered levels and enable word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= {NUM_CHAN{LEVEL_NONE}};
      en_q  <= ENABLE_NONE;
    end else if (accept) begin
      lvl_q <= lvl;
      en_q  <= en_d;
    end
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      job_valid_q <= accept;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

>>> src/rlw_outbuf.sv
// Output buffer: divides the products by 99, holds up to four register writes
// of one request, sends one a cycle while tready is high. Depends on rlw_pkg.
`timescale 1ns / 1ps

module rlw_outbuf
  import rlw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_take_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // reg_index, reg_value, zero pad
  output logic        m_axis_tlast    // last_write
);

  localparam int unsigned SLOTS = NUM_CHAN + 1;

  logic [SLOTS-1:0]      pend_q;
  logic [SLOTS-1:0][7:0] val_q;

  logic [SLOTS-1:0]      pend_d;
  logic [SLOTS-1:0][7:0] val_d;
  logic [1:0]            sel;
  logic [SLOTS-1:0]      sel_mask;
  logic                  fire;
  logic                  done;
  logic                  load;
  logic [30:0]           quot_full [NUM_CHAN];
  reg_idx_e              idx;

  // Slot order: red, green, blue current, then enable word
  function automatic reg_idx_e slot_reg(input logic [1:0] s);
    unique case (s)
      2'd0:    slot_reg = REG_RED;
      2'd1:    slot_reg = REG_GREEN;
      2'd2:    slot_reg = REG_BLUE;
      default: slot_reg = REG_ENABLE;
    endcase
  endfunction

  // Divide by 99 through the reciprocal
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      quot_full[c] = {16'd0, job_i.prod[c]} * {15'd0, RECIP_99};
      val_d[c]     = quot_full[c][RECIP_SHIFT +: 8];
    end
    val_d[NUM_CHAN] = job_i.en_value;
  end

  // Lowest pending slot goes first
  always_comb begin
    if (pend_q[0]) begin
      sel = 2'd0;
    end else if (pend_q[1]) begin
      sel = 2'd1;
    end else if (pend_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    sel_mask = SLOTS'(1) << sel;
  end

  assign m_axis_tvalid = |pend_q;
  assign m_axis_tlast  = ((pend_q & (pend_q - SLOTS'(1))) == '0);
  assign idx           = slot_reg(sel);
  assign m_axis_tdata  = {6'd0, val_q[sel], idx};

  assign fire       = m_axis_tvalid && m_axis_tready;
  assign done       = fire && m_axis_tlast;
  assign load       = job_valid_i && (!m_axis_tvalid || done);
  assign job_take_o = load;
  assign pend_d     = {job_i.en_write, job_i.emit};

  // Pending writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (load) begin
      pend_q <= pend_d;
    end else if (fire) begin
      pend_q <= pend_q & ~sel_mask;
    end
  end

  // Register values
  always_ff @(posedge clk_i) begin
    if (load) begin
      val_q <= val_d;
    end
  end

endmodule

>>> src/rgb_led_register_writer.sv
// Top level of the RGB LED register writer: configuration port, input stage
// and output buffer. Depends on rlw_pkg, rlw_cfg_regs, rlw_front, rlw_outbuf.
`timescale 1ns / 1ps

// Each input word carries red, green and blue power requests (percent,
// saturated to 100). The block compares them with the levels it last saw and
// emits register writes in red, green, blue order: a current code of
// (level-1)*full_scale/99 for every channel that changed to a nonzero level,
// then the enable word to register 3 if it changed. A request gives zero to
// four output words; tlast marks the last of them. A request is registered in
// the input stage and then in the output buffer before its writes leave. The
// output buffer sends one word per cycle while tready is high and keeps a
// request until all its writes (one to four) are out; meanwhile the input
// stage can take the next request. full_scale_code is written over APB at
// address 0 (reset value 39) and should only change while the block is idle.

module rgb_led_register_writer
  import rlw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] red_power, [15:8] green_power,
                                      // [23:16] blue_power
  // Register writes
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [1:0] reg_index, [9:2] reg_value, zero pad
  output logic        m_axis_tlast    // last_write
);

  logic [7:0] full_scale;
  logic       job_valid;
  logic       job_take;
  job_t       job;

  rlw_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .full_scale_o (full_scale)
  );

  rlw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .full_scale_i  (full_scale),
    .job_valid_o   (job_valid),
    .job_o         (job),
    .job_take_i    (job_take)
  );

  rlw_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job),
    .job_take_o    (job_take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // The enable word is always the final write of a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[1:0] == REG_ENABLE)) |-> m_axis_tlast)
    else $error("enable word not marked as last write");

  // Only the six channel enable bits can ever be set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[1:0] == REG_ENABLE)) |-> (m_axis_tdata[9:8] == 2'b00))
    else $error("enable word has bits outside the channel fields");

  // Input back-pressure only while the input stage holds work it cannot hand on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (job_valid && !job_take && m_axis_tvalid))
    else $error("input stalled without pending work");

  // A request taken is in the input stage on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> job_valid)
    else $error("accepted request lost");

endmodule

>>> dv/tb_rgb_led_register_writer.sv
// Testbench for the RGB LED register writer: drives power requests and APB
// writes of the full scale code, predicts every register write and checks it.
// Depends on rlw_pkg and rgb_led_register_writer.
`timescale 1ns / 1ps

module tb_rgb_led_register_writer
  import rlw_pkg::*;
();

  // Expected register writes, worked out from the requests the block accepts
  class led_write_scoreboard;

    typedef struct packed {
      reg_idx_e   idx;
      logic [7:0] value;
      logic       last;
    } reg_write_t;

    localparam int unsigned PERCENT_STEPS = 99;

    reg_write_t pending[$];
    logic [7:0] full_scale;
    logic [6:0] level_seen[NUM_CHAN];   // red, green, blue
    logic [7:0] enable_seen;
    int         errors;

    function new();
      full_scale  = FULL_SCALE_RESET;
      level_seen  = '{LEVEL_NONE, LEVEL_NONE, LEVEL_NONE};
      enable_seen = ENABLE_NONE;
      errors      = 0;
    endfunction

    function void set_full_scale(logic [7:0] code);
      full_scale = code;
    endfunction

    function void push_write(reg_idx_e idx, logic [7:0] value);
      reg_write_t w;
      w.idx   = idx;
      w.value = value;
      w.last  = 1'b0;
      pending.push_back(w);
    endfunction

    // Note one accepted request and queue the writes it causes
    function void note_request(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      logic [7:0] req[NUM_CHAN];
      reg_idx_e   chan_reg[NUM_CHAN];
      logic [6:0] level;
      logic [7:0] en;
      int         code;
      int         first;
      req      = '{red, green, blue};
      chan_reg = '{REG_RED, REG_GREEN, REG_BLUE};
      en       = (enable_seen == ENABLE_NONE) ? ENABLE_ALL : enable_seen;
      first    = pending.size();
      for (int c = 0; c < NUM_CHAN; c++) begin
        level = (req[c] > LEVEL_MAX) ? LEVEL_MAX : req[c][6:0];
        if (level != level_seen[c]) begin
          level_seen[c] = level;
          if (level == 0) begin
            en &= ENABLE_ALL & ~CHAN_BITS[c];
          end else begin
            en |= CHAN_BITS[c];
            code = ((int'(level) - 1) * int'(full_scale)) / PERCENT_STEPS;
            push_write(chan_reg[c], code[7:0]);
          end
        end
      end
      if (en != enable_seen) begin
        enable_seen = en;
        push_write(REG_ENABLE, en);
      end
      if (pending.size() > first) pending[pending.size()-1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    // Compare one output word with the oldest expected write
    task check_write(logic [1:0] idx, logic [7:0] value, logic last);
      reg_write_t w;
      if (pending.size() == 0) begin
        report($sformatf("unexpected write reg %0d value %0d", idx, value));
      end else begin
        w = pending.pop_front();
        if (idx !== w.idx)
          report($sformatf("reg index %0d, expected %0d", idx, w.idx));
        if (value !== w.value)
          report($sformatf("reg %0d value %0d, expected %0d", w.idx, value, w.value));
        if (last !== w.last)
          report($sformatf("tlast %b, expected %b", last, w.last));
      end
    endtask
  endclass

  localparam logic [2:0] FULL_SCALE_ADDR = {CFG_FULL_SCALE, 2'b00};
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned IDLE_PCT       = 27;
  localparam int unsigned RAND_PHASES    = 6;
  localparam int unsigned PHASE_ITEMS    = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        s_axis_tvalid, s_axis_tready;
  logic [23:0] s_axis_tdata;   // [7:0] red, [15:8] green, [23:16] blue
  logic        m_axis_tvalid, m_axis_tready;
  logic [15:0] m_axis_tdata;   // [1:0] reg_index, [9:2] reg_value, zero pad
  logic        m_axis_tlast;

  led_write_scoreboard sb = new();

  bit tx_steady;
  bit rx_steady;
  int hold_req;
  logic [7:0] last_req[NUM_CHAN];

  rgb_led_register_writer i_dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random back-pressure, steady stretches, and long hold-offs
  initial begin
    int hold_cnt;
    int hold_seen;
    hold_cnt  = 0;
    hold_seen = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_cnt  = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (rx_steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_write(m_axis_tdata[1:0], m_axis_tdata[9:2], m_axis_tlast);
  end

  // APB write of the full scale code: setup cycle, then access cycle
  task automatic write_full_scale(input logic [7:0] code);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FULL_SCALE_ADDR;
    pwdata  <= {24'd0, code};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_full_scale(code);
  endtask

  // Offer one request word, with random gaps ahead of it
  task automatic send_request(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {blue, green, red};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(red, green, blue);
    last_req = '{red, green, blue};
  endtask

  // Pause until every expected write is out and the block has settled
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random power: often keeps or zeroes a level, sometimes saturates, else any byte
  function automatic logic [7:0] pick_power(logic [7:0] prev);
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return prev;
    if (sel < 45) return 8'd0;
    if (sel < 55) return 8'($urandom_range(255, 101));
    return 8'($urandom_range(255));
  endfunction

  // Stimulus
  initial begin
    logic [7:0] fs_code[RAND_PHASES];
    fs_code = '{8'd255, 8'd0, 8'd1, 8'd127, 8'd39, 8'd0};
    fs_code[5] = 8'($urandom_range(255));
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: first request ever, no change, saturation, enable patterns
    send_request(8'd0, 8'd0, 8'd0);
    send_request(8'd0, 8'd0, 8'd0);
    send_request(8'd255, 8'd255, 8'd255);
    send_request(8'd100, 8'd101, 8'd200);
    send_request(8'd1, 8'd1, 8'd1);
    send_request(8'd0, 8'd1, 8'd1);
    send_request(8'd1, 8'd0, 8'd1);
    send_request(8'd1, 8'd1, 8'd0);
    send_request(8'h55, 8'hAA, 8'h80);
    send_request(8'd99, 8'd2, 8'd50);
    send_request(8'd0, 8'd0, 8'd0);
    wait_drained();
    write_full_scale(8'd255);
    send_request(8'd100, 8'd100, 8'd100);
    send_request(8'd2, 8'd2, 8'd2);
    send_request(8'd99, 8'd0, 8'h7F);
    wait_drained();
    write_full_scale(8'd0);
    send_request(8'd50, 8'd100, 8'd1);
    send_request(8'd0, 8'd0, 8'd0);

    // Random phases, one full scale setting each
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      write_full_scale(fs_code[p]);
      tx_steady = (p == 3);
      rx_steady = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 5) hold_req++;
        if ($urandom_range(99) < 10)
          send_request(last_req[0], last_req[1], last_req[2]);
        else
          send_request(pick_power(last_req[0]), pick_power(last_req[1]),
                       pick_power(last_req[2]));
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.pending.size() == 0 && sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Run limit
  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> rgb_led_register_writer.f
src/rlw_pkg.sv
src/rlw_cfg_regs.sv
src/rlw_front.sv
src/rlw_outbuf.sv
src/rgb_led_register_writer.sv
dv/tb_rgb_led_register_writer.sv
